[design/itpt_pkg.sv]
// Shared types, character codes and flag positions for the integer text formatter.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps

package itpt_pkg;

  // One input item: the number and its formatting controls.
  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
    logic [6:0]  min_width;
    logic [5:0]  min_digits;
    logic [6:0]  format_flags;
  } itpt_in_t;

  // One result item: a single character of the formatted text.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
    logic       bad_base;
  } itpt_out_t;

  // Bit positions inside format_flags.
  localparam int FlagZeropad = 0;
  localparam int FlagSigned  = 1;
  localparam int FlagPlus    = 2;
  localparam int FlagSpace   = 3;
  localparam int FlagLeft    = 4;
  localparam int FlagPrefix  = 5;
  localparam int FlagLower   = 6;

  // Legal range of the number base and the bases that take a prefix.
  localparam logic [5:0] MinRadix   = 6'd2;
  localparam logic [5:0] MaxRadix   = 6'd36;
  localparam logic [5:0] OctalRadix = 6'd8;
  localparam logic [5:0] HexRadix   = 6'd16;

  // ASCII codes used by the formatter.
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharUpperX = 8'h58;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [5:0] DecDigits  = 6'd10;

  // Maps a digit value 0..35 to its character in the upper or lower case set.
  function automatic logic [7:0] digit_char(input logic [5:0] digit, input logic lower);
    logic [7:0] base_char;
    base_char = lower ? CharLowerA : CharUpperA;
    if (digit < DecDigits) begin
      return CharZero + {2'b00, digit};
    end
    return base_char + {2'b00, digit - DecDigits};
  endfunction

endpackage

[design/itpt_divider.sv]
// Iterative restoring divider: a VALUE_BITS dividend by a 6-bit base, one bit a cycle.
// Depends on nothing but the clock and reset; used by the top level for each digit.
`timescale 1ns / 1ps

module itpt_divider #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [5:0]            divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [5:0]            remainder_o
);

  localparam int CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] work_q, work_d;
  logic [5:0]            rem_q, rem_d;
  logic [CntW-1:0]       cnt_q;
  logic                  run_q;
  logic                  done_q;
  logic [6:0]            trial;
  logic                  fits;

  // One restoring step: shift the next dividend bit into the remainder and
  // subtract the base when it fits. The quotient bit replaces the used bit.
  always_comb begin
    trial  = {rem_q, work_q[VALUE_BITS-1]};
    fits   = (trial >= {1'b0, divisor_i});
    rem_d  = fits ? 6'(trial - {1'b0, divisor_i}) : trial[5:0];
    work_d = {work_q[VALUE_BITS-2:0], fits};
  end

  // Step counter and operand registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= '0;
        work_q <= dividend_i;
        rem_q  <= '0;
      end else if (run_q) begin
        work_q <= work_d;
        rem_q  <= rem_d;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

[design/itpt_digit_stack.sv]
// Last-in first-out shift stack that turns digits produced least significant first
// into most-significant-first order. No dependencies.
`timescale 1ns / 1ps

module itpt_digit_stack #(
  parameter int DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       push_i,
  input  logic       pop_i,
  input  logic [5:0] digit_i,
  output logic [5:0] top_o
);

  logic [5:0] stack_q [DEPTH];

  // A push moves every entry one place deeper; a pop moves them one place up.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      stack_q[0] <= digit_i;
      for (int i = 1; i < DEPTH; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop_i) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
      stack_q[DEPTH-1] <= '0;
    end
  end

  assign top_o = stack_q[0];

endmodule

[design/integer_to_padded_text.sv]
// Top level of the printf-style integer formatter: sequencer, layout and character output.
// Depends on itpt_pkg, itpt_divider and itpt_digit_stack.
`timescale 1ns / 1ps

// Usage:
//   An item is taken at a rising edge where start_i is high and busy_o is low.
//   item_i carries the number, base, field width, precision and flags.
//   The text leaves one character per cycle on res_o, marked by out_valid_o,
//   in order: leading spaces, sign, prefix, zero padding, digits, trailing
//   spaces. The final character has last_char set.
//   A base outside 2..36 gives one result with bad_base and last_char set
//   in the cycle after the item is taken, and busy_o stays low.
// Throughput:
//   Digits come from one shared divider that retires one quotient bit per
//   cycle, one division per digit; a value of zero still costs one
//   division. A layout step follows, then the characters at one per cycle
//   (at most MAX_CHARS). busy_o is high throughout.
// Reset:
//   rst_ni clears the sequencer to idle with no result pending.
//   Results cannot be held off: each one is present for exactly one cycle.
module integer_to_padded_text #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  itpt_pkg::itpt_in_t   item_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  output itpt_pkg::itpt_out_t  res_o
);

  import itpt_pkg::*;

  localparam int PosW = $clog2(MAX_CHARS + VALUE_BITS + 4);
  localparam int NdW  = $clog2(VALUE_BITS + 1);
  localparam logic [PosW-1:0] MaxChars = PosW'(MAX_CHARS);
  localparam logic [PosW-1:0] MaxPrec  = PosW'(MAX_CHARS - 3);

  typedef enum logic [2:0] {
    StIdle,
    StWait,
    StLayout,
    StEmit
  } state_e;

  state_e                state_q;
  logic                  out_valid_q;
  itpt_out_t             res_q;
  logic                  div_start_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [5:0]            base_q;
  logic [7:0]            sign_char_q;
  logic                  has_sign_q;
  logic [1:0]            plen_q;
  logic                  lower_q;
  logic                  left_q;
  logic                  zp_q;
  logic [PosW-1:0]       width_q;
  logic [PosW-1:0]       prec_q;
  logic [NdW-1:0]        nd_q;
  logic [PosW-1:0]       k_q;
  logic [PosW-1:0]       b_lead_q, b_sign_q, b_pre_q, b_prec_q, b_dig_q, n_q;

  // Divider and digit stack.
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  logic [5:0]            remainder;
  logic                  push;
  logic                  pop;
  logic [5:0]            top_digit;

  itpt_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (mag_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  itpt_digit_stack #(
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk_i  (clk_i),
    .push_i (push),
    .pop_i  (pop),
    .digit_i(remainder),
    .top_o  (top_digit)
  );

  // Decode of an incoming item.
  logic                  accept;
  logic                  in_bad;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg;
  logic                  in_left;
  logic [1:0]            in_plen;
  logic [7:0]            in_sign_char;
  logic                  in_has_sign;
  logic [PosW-1:0]       in_width;
  logic [PosW-1:0]       in_prec;

  always_comb begin
    accept      = start_i && (state_q == StIdle);
    in_bad      = (item_i.radix < MinRadix) || (item_i.radix > MaxRadix);
    in_val      = item_i.value[VALUE_BITS-1:0];
    in_neg      = item_i.format_flags[FlagSigned] && in_val[VALUE_BITS-1];
    in_left     = item_i.format_flags[FlagLeft];
    in_has_sign = 1'b1;
    if (in_neg) begin
      in_sign_char = CharMinus;
    end else if (item_i.format_flags[FlagPlus]) begin
      in_sign_char = CharPlus;
    end else if (item_i.format_flags[FlagSpace]) begin
      in_sign_char = CharSpace;
    end else begin
      in_sign_char = CharNul;
      in_has_sign  = 1'b0;
    end
    in_plen = 2'd0;
    if (item_i.format_flags[FlagPrefix]) begin
      if (item_i.radix == HexRadix) begin
        in_plen = 2'd2;
      end else if (item_i.radix == OctalRadix) begin
        in_plen = 2'd1;
      end
    end
    in_width = (int'(item_i.min_width) > MAX_CHARS) ? MaxChars
                                                    : PosW'(item_i.min_width);
    in_prec  = (int'(item_i.min_digits) > MAX_CHARS - 3) ? MaxPrec
                                                         : PosW'(item_i.min_digits);
  end

  // Layout: where each segment of the text ends, from sign, prefix,
  // digit count, precision and field width.
  logic [PosW-1:0] nd_ext, prec_eff, need, pad;
  logic [PosW-1:0] lead_len, zpad_len, trail_len, total;
  logic [PosW-1:0] l_lead, l_sign, l_pre, l_prec, l_dig;

  always_comb begin
    nd_ext    = PosW'(nd_q);
    prec_eff  = (nd_ext > prec_q) ? nd_ext : prec_q;
    need      = PosW'(has_sign_q) + PosW'(plen_q) + prec_eff;
    pad       = (width_q > need) ? (width_q - need) : '0;
    lead_len  = (!zp_q && !left_q) ? pad : '0;
    zpad_len  = zp_q ? pad : '0;
    trail_len = left_q ? pad : '0;
    l_lead    = lead_len;
    l_sign    = l_lead + PosW'(has_sign_q);
    l_pre     = l_sign + PosW'(plen_q);
    l_prec    = l_pre + zpad_len + (prec_eff - nd_ext);
    l_dig     = l_prec + nd_ext;
    total     = l_dig + trail_len;
  end

  // Character at the current text position.
  logic [7:0] cur_char;
  logic       in_digits;
  logic       at_last;

  always_comb begin
    in_digits = (k_q >= b_prec_q) && (k_q < b_dig_q);
    at_last   = (k_q == n_q - 1'b1);
    if (k_q < b_lead_q) begin
      cur_char = CharSpace;
    end else if (k_q < b_sign_q) begin
      cur_char = sign_char_q;
    end else if (k_q < b_pre_q) begin
      cur_char = (k_q == b_sign_q) ? CharZero : (lower_q ? CharLowerX : CharUpperX);
    end else if (k_q < b_prec_q) begin
      cur_char = CharZero;
    end else if (in_digits) begin
      cur_char = digit_char(top_digit, lower_q);
    end else begin
      cur_char = CharSpace;
    end
    push = (state_q == StWait) && div_done;
    pop  = (state_q == StEmit) && in_digits;
  end

  // Sequencer: flag a bad base, or divide out the digits, lay out the text, then emit it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      div_start_q <= 1'b0;
      mag_q       <= '0;
      base_q      <= '0;
      sign_char_q <= '0;
      has_sign_q  <= 1'b0;
      plen_q      <= '0;
      lower_q     <= 1'b0;
      left_q      <= 1'b0;
      zp_q        <= 1'b0;
      width_q     <= '0;
      prec_q      <= '0;
      nd_q        <= '0;
      k_q         <= '0;
      b_lead_q    <= '0;
      b_sign_q    <= '0;
      b_pre_q     <= '0;
      b_prec_q    <= '0;
      b_dig_q     <= '0;
      n_q         <= '0;
    end else begin
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (in_bad) begin
              out_valid_q     <= 1'b1;
              res_q.out_char  <= CharNul;
              res_q.last_char <= 1'b1;
              res_q.bad_base  <= 1'b1;
            end else begin
              mag_q       <= in_neg ? (~in_val + 1'b1) : in_val;
              base_q      <= item_i.radix;
              sign_char_q <= in_sign_char;
              has_sign_q  <= in_has_sign;
              plen_q      <= in_plen;
              lower_q     <= item_i.format_flags[FlagLower];
              left_q      <= in_left;
              zp_q        <= item_i.format_flags[FlagZeropad] && !in_left;
              width_q     <= in_width;
              prec_q      <= in_prec;
              nd_q        <= '0;
              div_start_q <= 1'b1;
              state_q     <= StWait;
            end
          end
        end
        StWait: begin
          if (div_done) begin
            nd_q  <= nd_q + 1'b1;
            mag_q <= quotient;
            if (quotient == '0) begin
              state_q <= StLayout;
            end else begin
              div_start_q <= 1'b1;
            end
          end
        end
        StLayout: begin
          b_lead_q <= l_lead;
          b_sign_q <= l_sign;
          b_pre_q  <= l_pre;
          b_prec_q <= l_prec;
          b_dig_q  <= l_dig;
          n_q      <= (total > MaxChars) ? MaxChars : total;
          k_q      <= '0;
          state_q  <= StEmit;
        end
        StEmit: begin
          out_valid_q     <= 1'b1;
          res_q.out_char  <= cur_char;
          res_q.last_char <= at_last;
          res_q.bad_base  <= 1'b0;
          k_q             <= k_q + 1'b1;
          if (at_last) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
